[sv/bpc_pkg.sv]
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bpc_pkg;

   localparam int RAW_W      = 24;
   localparam int SC_W       = 31;
   localparam int FRAC       = 24;
   localparam int PIPE_DEPTH = 13;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 64;
   localparam int CALIB_C_W  = 40;

   // 2048/31 = 66 + 2/31; the remainder part is divided by reciprocal multiply
   localparam logic [6:0]  SCALE_WHOLE = 7'd66;
   localparam logic [4:0]  SCALE_BIAS  = 5'd15;
   localparam logic [25:0] RECIP_31    = 26'd34636834;
   localparam int          RECIP_SH    = 30;

   localparam logic [1:0] REG_CALIB_A = 2'd0;
   localparam logic [1:0] REG_CALIB_B = 2'd1;
   localparam logic [1:0] REG_CALIB_C = 2'd2;

   typedef struct packed {
      logic signed [RAW_W-1:0] press_code;
      logic signed [RAW_W-1:0] temp_code;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_q8;
      logic signed [31:0] pressure_q6;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [11:0] c0;
      logic signed [11:0] c1;
      logic signed [19:0] c00;
      logic signed [19:0] c10;
      logic signed [15:0] c01;
      logic signed [15:0] c11;
      logic signed [15:0] c20;
      logic signed [15:0] c21;
      logic signed [15:0] c30;
      logic signed [11:0] c31;
      logic signed [11:0] c40;
   } coeff_type;

endpackage

`default_nettype wire

[sv/bpc_csr.sv]
// Calibration register file with APB-style access and coefficient unpacking.
// Depends on bpc_pkg.
`default_nettype none

module bpc_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [bpc_pkg::CSR_AW-1:0] paddr,
   input  wire logic [bpc_pkg::CSR_DW-1:0] pwdata,
   output logic      [bpc_pkg::CSR_DW-1:0] prdata,
   output bpc_pkg::coeff_type              coeff_o
);
   import bpc_pkg::*;

   logic [63:0]          word_a_ff, word_a_in;
   logic [63:0]          word_b_ff, word_b_in;
   logic [CALIB_C_W-1:0] word_c_ff, word_c_in;
   logic                 wr_en;
   logic [1:0]           reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:3];

   always_comb begin
      word_a_in = word_a_ff;
      word_b_in = word_b_ff;
      word_c_in = word_c_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CALIB_A: word_a_in = pwdata;
            REG_CALIB_B: word_b_in = pwdata;
            REG_CALIB_C: word_c_in = pwdata[CALIB_C_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_a_ff <= '0;
         word_b_ff <= '0;
         word_c_ff <= '0;
      end else begin
         word_a_ff <= word_a_in;
         word_b_ff <= word_b_in;
         word_c_ff <= word_c_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CALIB_A: prdata = word_a_ff;
         REG_CALIB_B: prdata = word_b_ff;
         REG_CALIB_C: prdata = CSR_DW'(word_c_ff);
         default:     prdata = '0;
      endcase
   end

   assign coeff_o = coeff_type'({word_a_ff, word_b_ff, word_c_ff});

endmodule

`default_nettype wire

[sv/bpc_scale.sv]
// Two-stage scaler: raw 24-bit sample times 2^24/253952, rounded, to Q7.24.
// Depends on bpc_pkg.
`default_nettype none

module bpc_scale (
   input  wire logic                             clock,
   input  wire logic signed [bpc_pkg::RAW_W-1:0] raw_i,
   output logic signed      [bpc_pkg::SC_W-1:0]  sc_o
);
   import bpc_pkg::*;

   logic [RAW_W-1:0] mag;
   logic [RAW_W:0]   num;
   logic [50:0]      prod_in, prod_ff;
   logic [29:0]      whole_in, whole_ff;
   logic             neg_ff;
   logic [29:0]      quot;
   logic signed [SC_W-1:0] sc_in, sc_ff;

   assign mag      = raw_i[RAW_W-1] ? (~raw_i + 1'b1) : raw_i;
   assign num      = {mag, 1'b0} + (RAW_W+1)'(SCALE_BIAS);
   assign prod_in  = 51'(num) * 51'(RECIP_31);
   assign whole_in = 30'(mag) * 30'(SCALE_WHOLE);

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      whole_ff <= whole_in;
      neg_ff   <= raw_i[RAW_W-1];
   end

   assign quot  = whole_ff + 30'(prod_ff >> RECIP_SH);
   assign sc_in = neg_ff ? -signed'({1'b0, quot}) : signed'({1'b0, quot});

   always_ff @(posedge clock) begin
      sc_ff <= sc_in;
   end

   assign sc_o = sc_ff;

endmodule

`default_nettype wire

[sv/bpc_step.sv]
// One Horner step over two stages: y = c*2^24 + floor(a*b/2^24).
// The wide product is split at bit 24 of b into two partial products.
// Depends on bpc_pkg.
`default_nettype none

module bpc_step #(
   parameter int BW = 42,
   parameter int CW = 16,
   parameter int YW = 47
) (
   input  wire logic                            clock,
   input  wire logic signed [bpc_pkg::SC_W-1:0] a_i,
   input  wire logic signed [BW-1:0]            b_i,
   input  wire logic signed [CW-1:0]            c_i,
   output logic signed      [YW-1:0]            y_o,
   output logic signed      [bpc_pkg::SC_W-1:0] a_o
);
   import bpc_pkg::*;

   localparam int HW    = BW - FRAC;
   localparam int PW_LO = SC_W + FRAC + 1;
   localparam int PW_HI = SC_W + HW;

   logic signed [PW_LO-1:0] lo_in, lo_ff;
   logic signed [PW_HI-1:0] hi_in, hi_ff;
   logic signed [CW-1:0]    c_ff;
   logic signed [SC_W-1:0]  a1_ff, a2_ff;
   logic signed [YW-1:0]    y_in, y_ff;

   assign lo_in = PW_LO'(a_i) * PW_LO'(signed'({1'b0, b_i[FRAC-1:0]}));
   assign hi_in = PW_HI'(a_i) * PW_HI'(signed'(b_i[BW-1:FRAC]));

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      c_ff  <= c_i;
      a1_ff <= a_i;
   end

   assign y_in = (YW'(c_ff) <<< FRAC) + YW'(hi_ff) + YW'(lo_ff >>> FRAC);

   always_ff @(posedge clock) begin
      y_ff  <= y_in;
      a2_ff <= a1_ff;
   end

   assign y_o = y_ff;
   assign a_o = a2_ff;

endmodule

`default_nettype wire

[sv/bpc_round_sat.sv]
// Two-stage output conversion: round to nearest (ties away from zero) by SH
// bits, then clamp to signed 32 bits. Depends on bpc_pkg.
`default_nettype none

module bpc_round_sat #(
   parameter int W  = 58,
   parameter int SH = 18
) (
   input  wire logic                clock,
   input  wire logic signed [W-1:0] x_i,
   output logic signed      [31:0]  q_o,
   output logic                     clip_o
);
   import bpc_pkg::*;

   localparam int RW = W + 1 - SH;
   localparam int EW = (RW > 32) ? RW : 33;
   localparam logic signed [W:0]    HALF    = signed'((W+1)'(1) << (SH-1));
   localparam logic signed [W:0]    HALF_M1 = HALF - (W+1)'(1);
   localparam logic signed [EW-1:0] MAX_V   = EW'(34'sd2147483647);
   localparam logic signed [EW-1:0] MIN_V   = -MAX_V - EW'(1);

   logic signed [W:0]    sum;
   logic signed [RW-1:0] rnd_in, rnd_ff;
   logic signed [EW-1:0] ext;
   logic signed [31:0]   q_in, q_ff;
   logic                 clip_in, clip_ff;

   assign sum    = (W+1)'(x_i) + (x_i[W-1] ? HALF_M1 : HALF);
   assign rnd_in = RW'(sum >>> SH);

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
   end

   assign ext = EW'(rnd_ff);

   always_comb begin
      clip_in = 1'b1;
      priority if (ext > MAX_V) begin
         q_in = MAX_V[31:0];
      end else if (ext < MIN_V) begin
         q_in = MIN_V[31:0];
      end else begin
         q_in    = ext[31:0];
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      clip_ff <= clip_in;
   end

   assign q_o    = q_ff;
   assign clip_o = clip_ff;

endmodule

`default_nettype wire

[sv/baro_pressure_temp_compensation_top.sv]
// Barometric pressure and temperature compensation, thirteen-stage pipeline.
// Depends on bpc_pkg, bpc_csr, bpc_scale, bpc_step and bpc_round_sat.
//
// One raw pressure/temperature item is taken every clock cycle (busy stays
// low) and its result appears on rsp_data with rsp_valid high for one cycle.
// The pipeline runs through the scalers, four Horner steps (partial-product
// multiply, then add), one sum, one rounding and one clamping stage. The
// receiver cannot stall, so results must be captured when rsp_valid is high.
// Calibration words sit at byte addresses 0, 8 and 16 and must be written
// only while no item is in flight.
`default_nettype none

module baro_pressure_temp_compensation_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire bpc_pkg::req_type           req_data,
   output logic                            rsp_valid,
   output bpc_pkg::rsp_type                rsp_data,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [bpc_pkg::CSR_AW-1:0] paddr,
   input  wire logic [bpc_pkg::CSR_DW-1:0] pwdata,
   output logic      [bpc_pkg::CSR_DW-1:0] prdata,
   output logic                            pready
);
   import bpc_pkg::*;

   coeff_type coef;

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;

   logic signed [SC_W-1:0] p_sc, t_sc;
   logic signed [35:0]     c40_b, c31_b;
   logic signed [36:0]     c1_b;
   logic signed [41:0]     s1, u1;
   logic signed [43:0]     tm2;
   logic signed [SC_W-1:0] p1s, p1u, t1;
   logic signed [46:0]     s2, u2;
   logic signed [SC_W-1:0] p2s, p2u, p3s;
   logic signed [51:0]     s3, u3;
   logic signed [57:0]     ps, tu;
   logic signed [57:0]     pres_in, pres_ff;
   logic signed [SC_W-1:0] t_dly_ff [4];
   logic signed [43:0]     tm_dly_ff [7];
   logic signed [31:0]     temp_q, pres_q;
   logic                   clip_t, clip_p;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   bpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .coeff_o (coef)
   );

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   bpc_scale u_scale_p (.clock(clock), .raw_i(req_data.press_code), .sc_o(p_sc));
   bpc_scale u_scale_t (.clock(clock), .raw_i(req_data.temp_code),  .sc_o(t_sc));

   assign c40_b = {coef.c40, {FRAC{1'b0}}};
   assign c31_b = {coef.c31, {FRAC{1'b0}}};
   assign c1_b  = {coef.c1, {(FRAC+1){1'b0}}};

   bpc_step #(.BW(36), .CW(16), .YW(42)) u_s1 (
      .clock(clock), .a_i(p_sc), .b_i(c40_b), .c_i(coef.c30), .y_o(s1), .a_o(p1s)
   );
   bpc_step #(.BW(36), .CW(16), .YW(42)) u_u1 (
      .clock(clock), .a_i(p_sc), .b_i(c31_b), .c_i(coef.c21), .y_o(u1), .a_o(p1u)
   );
   // twice the temperature: c0*2^24 + 2*c1*t
   bpc_step #(.BW(37), .CW(12), .YW(44)) u_tm (
      .clock(clock), .a_i(t_sc), .b_i(c1_b), .c_i(coef.c0), .y_o(tm2), .a_o(t1)
   );

   bpc_step #(.BW(42), .CW(16), .YW(47)) u_s2 (
      .clock(clock), .a_i(p1s), .b_i(s1), .c_i(coef.c20), .y_o(s2), .a_o(p2s)
   );
   bpc_step #(.BW(42), .CW(16), .YW(47)) u_u2 (
      .clock(clock), .a_i(p1u), .b_i(u1), .c_i(coef.c11), .y_o(u2), .a_o(p2u)
   );

   bpc_step #(.BW(47), .CW(20), .YW(52)) u_s3 (
      .clock(clock), .a_i(p2s), .b_i(s2), .c_i(coef.c10), .y_o(s3), .a_o(p3s)
   );
   bpc_step #(.BW(47), .CW(16), .YW(52)) u_u3 (
      .clock(clock), .a_i(p2u), .b_i(u2), .c_i(coef.c01), .y_o(u3), .a_o()
   );

   bpc_step #(.BW(52), .CW(20), .YW(58)) u_ps (
      .clock(clock), .a_i(p3s), .b_i(s3), .c_i(coef.c00), .y_o(ps), .a_o()
   );
   bpc_step #(.BW(52), .CW(1), .YW(58)) u_tu (
      .clock(clock), .a_i(t_dly_ff[3]), .b_i(u3), .c_i(1'sb0), .y_o(tu), .a_o()
   );

   // hold t and the temperature sum until the pressure chain catches up
   always_ff @(posedge clock) begin
      t_dly_ff[0]  <= t1;
      tm_dly_ff[0] <= tm2;
      for (int i = 1; i < 4; i++) begin
         t_dly_ff[i] <= t_dly_ff[i-1];
      end
      for (int i = 1; i < 7; i++) begin
         tm_dly_ff[i] <= tm_dly_ff[i-1];
      end
   end

   assign pres_in = ps + tu;

   always_ff @(posedge clock) begin
      pres_ff <= pres_in;
   end

   bpc_round_sat #(.W(44), .SH(FRAC - 7)) u_rnd_t (
      .clock(clock), .x_i(tm_dly_ff[6]), .q_o(temp_q), .clip_o(clip_t)
   );
   bpc_round_sat #(.W(58), .SH(FRAC - 6)) u_rnd_p (
      .clock(clock), .x_i(pres_ff), .q_o(pres_q), .clip_o(clip_p)
   );

   assign rsp_valid               = vld_ff[PIPE_DEPTH-1];
   assign rsp_data.temperature_q8 = temp_q;
   assign rsp_data.pressure_q6    = pres_q;
   assign rsp_data.saturated      = clip_t | clip_p;

endmodule

`default_nettype wire
